// ----- hdl/sfaer_pkg.sv -----
// Shared constants, phase codes and types for the serial frame alarm event receiver.
`default_nettype none
package sfaer_pkg;

  localparam int unsigned ALARM_ENTRIES_DEFAULT = 256;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_COUNT  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd1;

  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h16;
  localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd60;

  localparam logic [BYTE_W-1:0] CMD_RAISE = 8'hF0;
  localparam logic [BYTE_W-1:0] CMD_CLEAR = 8'h00;

  localparam logic EVT_RAISED  = 1'b0;
  localparam logic EVT_CLEARED = 1'b1;

  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DEST = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SRC  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LEN  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;
  localparam logic [PHASE_W-1:0] PH_SUM  = 3'd5;

  typedef struct packed {
    logic              go;
    logic              raise;
    logic [BYTE_W-1:0] addr;
  } frame_done_t;

endpackage
`default_nettype wire

// ----- hdl/sfaer_rx_if.sv -----
// Received byte channel.
`default_nettype none
interface sfaer_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/sfaer_evt_if.sv -----
// Alarm event channel.
`default_nettype none
interface sfaer_evt_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] device_address;

  modport source (output valid, output event_kind, output device_address, input ready);
  modport sink (input valid, input event_kind, input device_address, output ready);
endinterface
`default_nettype wire

// ----- hdl/sfaer_parser.sv -----
// Frame parser: phase machine, checksum, length check and configuration registers.
`default_nettype none
module sfaer_parser #(
  parameter int unsigned ALARM_ENTRIES = sfaer_pkg::ALARM_ENTRIES_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [sfaer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfaer_pkg::CFG_DATA_W-1:0] cfg_data,
  sfaer_rx_if.sink                              rx,
  input  wire logic                             slot_free,
  output sfaer_pkg::frame_done_t                done
);
  import sfaer_pkg::*;

  localparam logic [BYTE_W:0] ENTRY_LIMIT = (BYTE_W+1)'(ALARM_ENTRIES);

  logic [BYTE_W-1:0]  start_byte;
  logic [BYTE_W-1:0]  max_length;
  logic [PHASE_W-1:0] phase;
  logic [BYTE_W-1:0]  byte_count;
  logic [BYTE_W-1:0]  running_sum;
  logic [BYTE_W-1:0]  frame_length;
  logic [BYTE_W-1:0]  source_address;
  logic [BYTE_W-1:0]  command_byte;

  logic              accept;
  logic [BYTE_W-1:0] c;
  logic [BYTE_W-1:0] sum_next;
  logic [BYTE_W-1:0] count_next;

  assign rx.ready   = (phase != PH_SUM) || slot_free;
  assign accept     = rx.valid && rx.ready;
  assign c          = rx.rx_byte;
  assign sum_next   = running_sum + c;
  assign count_next = byte_count + 8'd1;

  assign done.go    = accept && (phase == PH_SUM) && (running_sum == c)
                   && ((command_byte == CMD_RAISE) || (command_byte == CMD_CLEAR))
                   && ({1'b0, source_address} < ENTRY_LIMIT);
  assign done.raise = (command_byte == CMD_RAISE);
  assign done.addr  = source_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= START_BYTE_RESET;
      max_length     <= MAX_LENGTH_RESET;
      phase          <= PH_IDLE;
      byte_count     <= '0;
      running_sum    <= '0;
      frame_length   <= '0;
      source_address <= '0;
      command_byte   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_START_BYTE: start_byte <= cfg_data;
          CFG_MAX_LENGTH: max_length <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        case (phase)
          PH_DEST: begin
            running_sum <= sum_next;
            phase       <= PH_SRC;
          end
          PH_SRC: begin
            source_address <= c;
            running_sum    <= sum_next;
            phase          <= PH_LEN;
          end
          PH_LEN: begin
            if ((c != 8'd0) && (c <= max_length)) begin
              frame_length <= c;
              running_sum  <= sum_next;
              byte_count   <= '0;
              phase        <= PH_DATA;
            end else begin
              phase <= PH_IDLE;
            end
          end
          PH_DATA: begin
            if (byte_count == 8'd0) begin
              command_byte <= c;
            end
            running_sum <= sum_next;
            byte_count  <= count_next;
            if (count_next == frame_length) begin
              phase <= PH_SUM;
            end
          end
          PH_SUM: begin
            phase <= PH_IDLE;
          end
          default: begin
            if (c == start_byte) begin
              byte_count  <= '0;
              running_sum <= '0;
              phase       <= PH_DEST;
            end else begin
              phase <= PH_IDLE;
            end
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sfaer_alarm_table.sv -----
// Alarm flag memory with read-modify-write stage and event output register.
`default_nettype none
module sfaer_alarm_table #(
  parameter int unsigned ALARM_ENTRIES = sfaer_pkg::ALARM_ENTRIES_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  sfaer_pkg::frame_done_t      done,
  output logic                        slot_free,
  sfaer_evt_if.source                 evt
);
  import sfaer_pkg::*;

  localparam int unsigned AW = (ALARM_ENTRIES > 1) ? $clog2(ALARM_ENTRIES) : 1;

  logic                     mem [ALARM_ENTRIES];
  logic [ALARM_ENTRIES-1:0] written;

  logic [AW-1:0]     rd_idx;
  logic              rd_bit;
  logic              rd_written;
  logic              s2_go;
  logic              s2_raise;
  logic [BYTE_W-1:0] s2_addr;
  logic              flag;
  logic              wr_en;
  logic              out_valid;
  logic              out_kind;
  logic [BYTE_W-1:0] out_addr;

  assign rd_idx    = done.addr[AW-1:0];
  assign flag      = rd_written && rd_bit;
  assign wr_en     = s2_go && (s2_raise != flag);
  assign slot_free = !out_valid || evt.ready;

  assign evt.valid          = out_valid;
  assign evt.event_kind     = out_kind;
  assign evt.device_address = out_addr;

  always_ff @(posedge clk) begin
    if (done.go) begin
      rd_bit     <= mem[rd_idx];
      rd_written <= written[rd_idx];
      s2_raise   <= done.raise;
      s2_addr    <= done.addr;
    end
    if (wr_en) begin
      mem[s2_addr[AW-1:0]] <= s2_raise;
      out_kind             <= s2_raise ? EVT_RAISED : EVT_CLEARED;
      out_addr             <= s2_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      s2_go     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s2_go <= done.go;
      if (wr_en) begin
        written[s2_addr[AW-1:0]] <= 1'b1;
        out_valid                <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/serial_frame_alarm_event_receiver_top.sv -----
// Serial frame alarm event receiver, top level.
//
// Channels: rx carries one received serial byte per beat; evt carries one
// alarm event per beat (event_kind 0 raised, 1 cleared, plus the source
// device address). Configuration: cfg_wr_en writes cfg_data to register
// cfg_index (0 start byte, 1 maximum data length) at the clock edge.
// Throughput: one byte per cycle, except while a checksum beat is held off.
// Every byte is taken by the parser phase machine; the alarm flags sit in a
// one-port memory that is read on the checksum byte and written back in the
// following cycle when the flag changes. An event passes the read stage and
// the event output register on its way to evt. Frames are at least six bytes
// long, so read and write of the flag memory never overlap for the same entry.
// Reset (rst, synchronous): the parser waits for the start byte, the
// registers return to 0x16 and 60, and a per-entry written bit marks every
// alarm flag clear at once; no clearing pass is needed.
// Stall: while an event waits on evt, bytes keep flowing; only a checksum
// beat is held off until the event register drains.
`default_nettype none
module serial_frame_alarm_event_receiver_top #(
  parameter int unsigned ALARM_ENTRIES = sfaer_pkg::ALARM_ENTRIES_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [sfaer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfaer_pkg::CFG_DATA_W-1:0] cfg_data,
  sfaer_rx_if.sink                              rx,
  sfaer_evt_if.source                           evt
);
  import sfaer_pkg::*;

  frame_done_t done;
  logic        slot_free;

  sfaer_parser #(
    .ALARM_ENTRIES(ALARM_ENTRIES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .slot_free (slot_free),
    .done      (done)
  );

  sfaer_alarm_table #(
    .ALARM_ENTRIES(ALARM_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .done      (done),
    .slot_free (slot_free),
    .evt       (evt)
  );

endmodule
`default_nettype wire

// ----- hdl/sfaer_checker.sv -----
// Port-level checks for the serial frame alarm event receiver.
`default_nettype none
module sfaer_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_kind,
  input wire logic [7:0] out_addr
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_addr))
    else $error("event dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("event shown straight after reset");

  a_event_spacing: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("events closer than a frame apart");

  a_ready_while_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("byte input held off with no event pending");

endmodule

bind serial_frame_alarm_event_receiver_top sfaer_checker u_sfaer_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (rx.ready),
  .out_valid (evt.valid),
  .out_ready (evt.ready),
  .out_kind  (evt.event_kind),
  .out_addr  (evt.device_address)
);
`default_nettype wire
